FILE: design/w2s_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2s_pkg
// Shared types and constants of the world-to-screen projector
// ----------------------------------------------------------------------------
package w2s_pkg;

    localparam int CLIP_W    = 52;
    localparam int PROD_W    = 48;
    localparam int NUM_W     = 67;
    localparam int SQ_W      = 64;
    localparam int SREM_W    = 36;
    localparam int ITER_STEPS = 32;

    localparam logic [2:0] CFG_COEFF_A  = 3'd0;
    localparam logic [2:0] CFG_COEFF_B  = 3'd1;
    localparam logic [2:0] CFG_COEFF_C  = 3'd2;
    localparam logic [2:0] CFG_TRANS_XY = 3'd3;
    localparam logic [2:0] CFG_TRANS_ZW = 3'd4;
    localparam logic [2:0] CFG_VIEWPORT = 3'd5;

    localparam logic [63:0] RST_COEFF    = 64'd4096;
    localparam logic [63:0] RST_TRANS_XY = 64'd0;
    localparam logic [63:0] RST_TRANS_ZW = 64'h0001_0000_0000_0000;
    localparam logic [31:0] RST_VIEWPORT = 32'd70780800;

    typedef struct packed {
        logic signed [31:0] viewer_x;
        logic signed [31:0] viewer_y;
        logic signed [31:0] viewer_z;
        logic signed [31:0] object_x;
        logic signed [31:0] object_y;
        logic signed [31:0] object_z;
    } in_t;

    typedef struct packed {
        logic signed [31:0] screen_x;
        logic signed [31:0] screen_y;
        logic        [31:0] distance;
        logic               visible;
    } out_t;

    // state carried through the shared divide / square root steps
    typedef struct packed {
        logic                valid;
        logic                visible;
        logic                neg_x;
        logic                neg_y;
        logic                ov_x;
        logic                ov_y;
        logic                ov_s;
        logic [CLIP_W-1:0]   w;
        logic [CLIP_W-1:0]   rx;
        logic [CLIP_W-1:0]   ry;
        logic [31:0]         nbx;
        logic [31:0]         nby;
        logic [31:0]         qx;
        logic [31:0]         qy;
        logic [SREM_W-1:0]   srem;
        logic [SQ_W-1:0]     sval;
        logic [31:0]         root;
    } iter_t;

endpackage

FILE: design/world_to_screen_projector_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// world_to_screen_projector_unit
// Perspective projection of an object point to screen pixels, with distance
// ----------------------------------------------------------------------------
// Takes one request per cycle while in_stall is low and returns one result per
// request, in order. Clip products, sums, the visibility test and the viewport
// scale run in five stages; then 32 shared stages each give one
// quotient bit of the x and y divide by clip w and one bit of the distance
// square root; a final stage adds the viewport offset and saturates. The
// output register plus one skid entry keep the pipe flowing; input stall is
// raised only while the skid entry is occupied. Configuration writes are
// always ready and must be made while no request is in flight.
module world_to_screen_projector_unit
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  w2s_pkg::in_t    in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output w2s_pkg::out_t   out_data,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [2:0]      cfg_index,
    input  logic [63:0]     cfg_data
);

    localparam int CW = w2s_pkg::CLIP_W;
    localparam int PW = w2s_pkg::PROD_W;
    localparam int NW = w2s_pkg::NUM_W;

    logic [63:0] coeff_a_reg;
    logic [63:0] coeff_b_reg;
    logic [63:0] coeff_c_reg;
    logic [63:0] trans_xy_reg;
    logic [63:0] trans_zw_reg;
    logic [31:0] viewport_reg;

    logic [14:0] hw;
    logic [14:0] hh;
    logic        en;

    assign cfg_ready = 1'b1;
    assign hw = viewport_reg[15:1];
    assign hh = viewport_reg[31:17];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coeff_a_reg  <= w2s_pkg::RST_COEFF;
            coeff_b_reg  <= w2s_pkg::RST_COEFF;
            coeff_c_reg  <= w2s_pkg::RST_COEFF;
            trans_xy_reg <= w2s_pkg::RST_TRANS_XY;
            trans_zw_reg <= w2s_pkg::RST_TRANS_ZW;
            viewport_reg <= w2s_pkg::RST_VIEWPORT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                w2s_pkg::CFG_COEFF_A:  coeff_a_reg  <= cfg_data;
                w2s_pkg::CFG_COEFF_B:  coeff_b_reg  <= cfg_data;
                w2s_pkg::CFG_COEFF_C:  coeff_c_reg  <= cfg_data;
                w2s_pkg::CFG_TRANS_XY: trans_xy_reg <= cfg_data;
                w2s_pkg::CFG_TRANS_ZW: trans_zw_reg <= cfg_data;
                w2s_pkg::CFG_VIEWPORT: viewport_reg <= cfg_data[31:0];
                default:               ;
            endcase
        end
    end

    // ---------------- stage a: products and absolute differences
    logic                 a_valid_reg;
    logic signed [PW-1:0] a_px_reg [3];
    logic signed [PW-1:0] a_py_reg [3];
    logic signed [PW-1:0] a_pw_reg [3];
    logic        [31:0]   a_ad_reg [3];
    logic signed [PW-1:0] a_px_next [3];
    logic signed [PW-1:0] a_py_next [3];
    logic signed [PW-1:0] a_pw_next [3];
    logic        [31:0]   a_ad_next [3];

    always_comb
    begin
        logic signed [32:0] d [3];
        a_px_next[0] = in_data.object_x * $signed(coeff_a_reg[15:0]);
        a_px_next[1] = in_data.object_y * $signed(coeff_a_reg[31:16]);
        a_px_next[2] = in_data.object_z * $signed(coeff_a_reg[47:32]);
        a_py_next[0] = in_data.object_x * $signed(coeff_a_reg[63:48]);
        a_py_next[1] = in_data.object_y * $signed(coeff_b_reg[15:0]);
        a_py_next[2] = in_data.object_z * $signed(coeff_b_reg[31:16]);
        a_pw_next[0] = in_data.object_x * $signed(coeff_c_reg[31:16]);
        a_pw_next[1] = in_data.object_y * $signed(coeff_c_reg[47:32]);
        a_pw_next[2] = in_data.object_z * $signed(coeff_c_reg[63:48]);
        d[0] = {in_data.object_x[31], in_data.object_x}
             - {in_data.viewer_x[31], in_data.viewer_x};
        d[1] = {in_data.object_y[31], in_data.object_y}
             - {in_data.viewer_y[31], in_data.viewer_y};
        d[2] = {in_data.object_z[31], in_data.object_z}
             - {in_data.viewer_z[31], in_data.viewer_z};
        for (int k = 0; k < 3; k++)
        begin
            a_ad_next[k] = d[k][32] ? 32'(-d[k]) : d[k][31:0];
        end
    end

    // ---------------- stage b: clip sums and squares
    logic                 b_valid_reg;
    logic signed [CW-1:0] b_cx_reg;
    logic signed [CW-1:0] b_cy_reg;
    logic signed [CW-1:0] b_cw_reg;
    logic        [63:0]   b_sq_reg [3];
    logic signed [CW-1:0] b_cx_next;
    logic signed [CW-1:0] b_cy_next;
    logic signed [CW-1:0] b_cw_next;

    always_comb
    begin
        logic signed [CW-1:0] tx;
        logic signed [CW-1:0] ty;
        logic signed [CW-1:0] tw;
        tx = CW'($signed(trans_xy_reg[31:0])) <<< 12;
        ty = CW'($signed(trans_xy_reg[63:32])) <<< 12;
        tw = CW'($signed(trans_zw_reg[63:32])) <<< 12;
        b_cx_next = CW'(a_px_reg[0]) + CW'(a_px_reg[1]) + CW'(a_px_reg[2]) + tx;
        b_cy_next = CW'(a_py_reg[0]) + CW'(a_py_reg[1]) + CW'(a_py_reg[2]) + ty;
        b_cw_next = CW'(a_pw_reg[0]) + CW'(a_pw_reg[1]) + CW'(a_pw_reg[2]) + tw;
    end

    // ---------------- stage c: visibility, magnitudes, sum of squares
    logic                 c_valid_reg;
    logic                 c_visible_reg;
    logic                 c_neg_x_reg;
    logic                 c_neg_y_reg;
    logic        [CW-1:0] c_mag_x_reg;
    logic        [CW-1:0] c_mag_y_reg;
    logic        [CW-1:0] c_w_reg;
    logic        [63:0]   c_s_reg;
    logic                 c_ov_s_reg;
    logic                 c_visible_next;
    logic        [65:0]   c_ssum;

    always_comb
    begin
        logic signed [CW+3:0] cw10;
        cw10 = (($bits(cw10))'(b_cw_reg) <<< 3) + (($bits(cw10))'(b_cw_reg) <<< 1);
        c_visible_next = cw10 >= $signed(($bits(cw10))'(64'h1000_0000));
        c_ssum = {2'b00, b_sq_reg[0]} + {2'b00, b_sq_reg[1]} + {2'b00, b_sq_reg[2]};
    end

    // ---------------- stage d: viewport scale
    logic                 d_valid_reg;
    logic                 d_visible_reg;
    logic                 d_neg_x_reg;
    logic                 d_neg_y_reg;
    logic        [NW-1:0] d_nx_reg;
    logic        [NW-1:0] d_ny_reg;
    logic        [CW-1:0] d_w_reg;
    logic        [63:0]   d_s_reg;
    logic                 d_ov_s_reg;

    // ---------------- stage e: overflow test and divide setup
    w2s_pkg::iter_t e_next;
    w2s_pkg::iter_t e_reg;
    w2s_pkg::iter_t chain [w2s_pkg::ITER_STEPS+1];

    always_comb
    begin
        logic [NW:0] wsh;
        wsh = {d_w_reg, 16'b0};
        e_next.valid   = d_valid_reg;
        e_next.visible = d_visible_reg;
        e_next.neg_x   = d_neg_x_reg;
        e_next.neg_y   = d_neg_y_reg;
        e_next.ov_x    = {1'b0, d_nx_reg} >= wsh;
        e_next.ov_y    = {1'b0, d_ny_reg} >= wsh;
        e_next.ov_s    = d_ov_s_reg;
        e_next.w       = d_w_reg;
        e_next.rx      = {1'b0, d_nx_reg[NW-1:16]};
        e_next.ry      = {1'b0, d_ny_reg[NW-1:16]};
        e_next.nbx     = {d_nx_reg[15:0], 16'b0};
        e_next.nby     = {d_ny_reg[15:0], 16'b0};
        e_next.qx      = '0;
        e_next.qy      = '0;
        e_next.srem    = '0;
        e_next.sval    = d_s_reg;
        e_next.root    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_reg       <= '0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
            e_reg       <= e_next;
        end
    end

    assign chain[0] = e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_px_reg <= a_px_next;
            a_py_reg <= a_py_next;
            a_pw_reg <= a_pw_next;
            a_ad_reg <= a_ad_next;

            b_cx_reg <= b_cx_next;
            b_cy_reg <= b_cy_next;
            b_cw_reg <= b_cw_next;
            for (int k = 0; k < 3; k++)
            begin
                b_sq_reg[k] <= a_ad_reg[k] * a_ad_reg[k];
            end

            c_visible_reg <= c_visible_next;
            c_neg_x_reg   <= b_cx_reg[CW-1];
            c_neg_y_reg   <= b_cy_reg[CW-1];
            c_mag_x_reg   <= b_cx_reg[CW-1] ? CW'(-b_cx_reg) : b_cx_reg;
            c_mag_y_reg   <= b_cy_reg[CW-1] ? CW'(-b_cy_reg) : b_cy_reg;
            c_w_reg       <= b_cw_reg;
            c_s_reg       <= c_ssum[63:0];
            c_ov_s_reg    <= |c_ssum[65:64];

            d_visible_reg <= c_visible_reg;
            d_neg_x_reg   <= c_neg_x_reg;
            d_neg_y_reg   <= c_neg_y_reg;
            d_nx_reg      <= c_mag_x_reg * hw;
            d_ny_reg      <= c_mag_y_reg * hh;
            d_w_reg       <= c_w_reg;
            d_s_reg       <= c_s_reg;
            d_ov_s_reg    <= c_ov_s_reg;
        end
    end

    for (genvar g = 0; g < w2s_pkg::ITER_STEPS; g++)
    begin : g_iter
        w2s_iter_stage u_step
        (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .cur   (chain[g]),
            .step  (chain[g+1])
        );
    end

    // ---------------- final stage: sign, offset, saturation
    function automatic logic [31:0] sat32(input logic signed [34:0] v);
        logic [31:0] r;
        if (v > 35'sd2147483647)
        begin
            r = 32'h7FFF_FFFF;
        end
        else if (v < -35'sd2147483648)
        begin
            r = 32'h8000_0000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

    w2s_pkg::iter_t fin;
    w2s_pkg::out_t  p_next;
    w2s_pkg::out_t  p_reg;
    logic           p_valid_reg;

    assign fin = chain[w2s_pkg::ITER_STEPS];

    always_comb
    begin
        logic signed [34:0] qx;
        logic signed [34:0] qy;
        logic signed [34:0] tx;
        logic signed [34:0] ty;
        qx = $signed({3'b000, fin.qx});
        qy = $signed({3'b000, fin.qy});
        tx = (fin.neg_x ? -qx : qx) + $signed({4'b0000, hw, 16'b0});
        ty = $signed({4'b0000, hh, 16'b0}) - (fin.neg_y ? -qy : qy);
        p_next = '0;
        if (fin.visible)
        begin
            p_next.visible  = 1'b1;
            p_next.screen_x = fin.ov_x ? (fin.neg_x ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                       : sat32(tx);
            p_next.screen_y = fin.ov_y ? (fin.neg_y ? 32'h7FFF_FFFF : 32'h8000_0000)
                                       : sat32(ty);
            p_next.distance = fin.ov_s ? 32'hFFFF_FFFF : fin.root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= p_next;
        end
    end

    // ---------------- output register with one skid entry
    w2s_pkg::out_t out_data_reg;
    w2s_pkg::out_t skid_data_reg;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    logic          out_take;

    assign en       = !skid_valid_reg;
    assign in_stall = skid_valid_reg;
    assign out_take = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= p_valid_reg;
            end
        end
        else if (p_valid_reg && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : p_reg;
        end
        else if (en)
        begin
            skid_data_reg <= p_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: design/w2s_iter_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// w2s_iter_stage
// One registered step: a quotient bit for x and y and a root bit for distance
// ----------------------------------------------------------------------------
module w2s_iter_stage
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  w2s_pkg::iter_t cur,
    output w2s_pkg::iter_t step
);

    w2s_pkg::iter_t step_reg;
    w2s_pkg::iter_t step_next;

    always_comb
    begin
        logic [w2s_pkg::CLIP_W:0]   rrx;
        logic [w2s_pkg::CLIP_W:0]   rry;
        logic [w2s_pkg::CLIP_W:0]   wext;
        logic [w2s_pkg::SREM_W-1:0] srr;
        logic [w2s_pkg::SREM_W-1:0] trial;
        step_next = cur;
        wext = {1'b0, cur.w};
        rrx  = {cur.rx, cur.nbx[31]};
        rry  = {cur.ry, cur.nby[31]};
        if (rrx >= wext)
        begin
            rrx = rrx - wext;
            step_next.qx = {cur.qx[30:0], 1'b1};
        end
        else
        begin
            step_next.qx = {cur.qx[30:0], 1'b0};
        end
        if (rry >= wext)
        begin
            rry = rry - wext;
            step_next.qy = {cur.qy[30:0], 1'b1};
        end
        else
        begin
            step_next.qy = {cur.qy[30:0], 1'b0};
        end
        step_next.rx  = rrx[w2s_pkg::CLIP_W-1:0];
        step_next.ry  = rry[w2s_pkg::CLIP_W-1:0];
        step_next.nbx = {cur.nbx[30:0], 1'b0};
        step_next.nby = {cur.nby[30:0], 1'b0};

        // digit-by-digit root, two radicand bits per step
        srr   = {cur.srem[w2s_pkg::SREM_W-3:0], cur.sval[w2s_pkg::SQ_W-1 -: 2]};
        trial = {2'b00, cur.root, 2'b01};
        if (srr >= trial)
        begin
            step_next.srem = srr - trial;
            step_next.root = {cur.root[30:0], 1'b1};
        end
        else
        begin
            step_next.srem = srr;
            step_next.root = {cur.root[30:0], 1'b0};
        end
        step_next.sval = {cur.sval[w2s_pkg::SQ_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (en)
        begin
            step_reg <= step_next;
        end
    end

    assign step = step_reg;

endmodule
